@@ sv/lfu_pkg.sv @@
// Shared types and codes of the LFU victim selector.
package lfu_pkg;

   localparam int COUNT_W    = 16;
   localparam int STAMP_W    = 32;
   localparam int KEY_W      = COUNT_W + STAMP_W;
   localparam int SLOT_W     = 4;
   localparam int SLOT_EXT_W = 9;
   localparam int CMD_W      = 2;
   localparam int STATUS_W   = 2;

   localparam logic [CMD_W-1:0] CMD_ADD    = 2'd0;
   localparam logic [CMD_W-1:0] CMD_REMOVE = 2'd1;
   localparam logic [CMD_W-1:0] CMD_EVICT  = 2'd2;

   localparam logic [STATUS_W-1:0] STATUS_OK        = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_UNTRACKED = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_EMPTY     = 2'd2;

   typedef enum logic [1:0] {
      STATE_IDLE,
      STATE_SCAN,
      STATE_DONE
   } state_type;

endpackage

@@ sv/lfu_victim_selector_unit.sv @@
// LFU victim selector: per-slot count/stamp memory and a serial evict scan.
// Add, remove and no-op commands finish in the cycle they are accepted and
// their beat appears on the rsp channel on the next cycle. Evict walks every
// slot through the single read port of the count/stamp memory, one slot per
// cycle, into one 48-bit comparator on {count, stamp}; it holds req_ready low
// through the scan state and then the result state (SCAN, then DONE). The
// victim is the tracked slot with the lowest count, then the oldest stamp,
// then the lowest index; it is untracked and reported. Count and stamp of an
// untracked slot are never reported, so the memory needs no clearing pass.
module lfu_victim_selector_unit
   import lfu_pkg::*;
#(
   parameter int SLOTS = 16
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  logic [CMD_W-1:0]    req_command,
   input  logic [SLOT_W-1:0]   req_slot,
   input  logic [COUNT_W-1:0]  req_use_count,
   input  logic [STAMP_W-1:0]  req_stamp,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output logic [STATUS_W-1:0] rsp_status,
   output logic [SLOT_W-1:0]   rsp_victim_slot,
   output logic [COUNT_W-1:0]  rsp_victim_count,
   output logic [STAMP_W-1:0]  rsp_victim_stamp
);

   localparam int IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
   localparam logic [IDX_W:0]        SLOTS_N   = (IDX_W + 1)'(SLOTS);
   localparam logic [SLOT_EXT_W-1:0] SLOTS_EXT = SLOT_EXT_W'(SLOTS);

   state_type state_ff, state_in;

   logic [SLOTS-1:0]    tracked_ff, tracked_in;
   logic [IDX_W:0]      scan_idx_ff, scan_idx_in;
   logic                cmp_valid_ff, cmp_valid_in;
   logic [IDX_W-1:0]    cmp_idx_ff, cmp_idx_in;
   logic                found_ff, found_in;
   logic [IDX_W-1:0]    best_ff, best_in;
   logic [KEY_W-1:0]    best_key_ff, best_key_in;
   logic [KEY_W-1:0]    rd_data_ff;

   logic                rsp_valid_ff, rsp_valid_in;
   logic [STATUS_W-1:0] rsp_status_ff, rsp_status_in;
   logic [SLOT_W-1:0]   rsp_slot_ff, rsp_slot_in;
   logic [COUNT_W-1:0]  rsp_count_ff, rsp_count_in;
   logic [STAMP_W-1:0]  rsp_stamp_ff, rsp_stamp_in;

   logic [KEY_W-1:0]    mem [SLOTS];
   logic                wr_en;
   logic [IDX_W-1:0]    rd_addr;

   logic [SLOT_EXT_W-1:0] slot_ext;
   logic [SLOT_EXT_W-1:0] best_ext;
   logic [IDX_W-1:0]      req_addr;
   logic                  slot_ok;
   logic                  scan_live;
   logic                  accept;

   assign slot_ext  = SLOT_EXT_W'(req_slot);
   assign req_addr  = slot_ext[IDX_W-1:0];
   assign slot_ok   = slot_ext < SLOTS_EXT;
   assign best_ext  = SLOT_EXT_W'(best_ff);
   assign scan_live = scan_idx_ff < SLOTS_N;
   assign rd_addr   = scan_live ? scan_idx_ff[IDX_W-1:0] : '0;
   assign req_ready = (state_ff == STATE_IDLE) && (!rsp_valid_ff || rsp_ready);
   assign accept    = req_valid && req_ready;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[req_addr] <= {req_use_count, req_stamp};
      end
      rd_data_ff <= mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= STATE_IDLE;
         tracked_ff   <= '0;
         cmp_valid_ff <= 1'b0;
         found_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
         scan_idx_ff  <= '0;
      end else begin
         state_ff     <= state_in;
         tracked_ff   <= tracked_in;
         cmp_valid_ff <= cmp_valid_in;
         found_ff     <= found_in;
         rsp_valid_ff <= rsp_valid_in;
         scan_idx_ff  <= scan_idx_in;
      end
   end

   always_ff @(posedge clock) begin
      cmp_idx_ff    <= cmp_idx_in;
      best_ff       <= best_in;
      best_key_ff   <= best_key_in;
      rsp_status_ff <= rsp_status_in;
      rsp_slot_ff   <= rsp_slot_in;
      rsp_count_ff  <= rsp_count_in;
      rsp_stamp_ff  <= rsp_stamp_in;
   end

   always_comb begin
      state_in      = state_ff;
      tracked_in    = tracked_ff;
      scan_idx_in   = scan_idx_ff;
      cmp_valid_in  = 1'b0;
      cmp_idx_in    = cmp_idx_ff;
      found_in      = found_ff;
      best_in       = best_ff;
      best_key_in   = best_key_ff;
      rsp_valid_in  = rsp_valid_ff;
      rsp_status_in = rsp_status_ff;
      rsp_slot_in   = rsp_slot_ff;
      rsp_count_in  = rsp_count_ff;
      rsp_stamp_in  = rsp_stamp_ff;
      wr_en         = 1'b0;

      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end

      // compare stage: keep the earlier slot on a full tie
      if (cmp_valid_ff && (!found_ff || rd_data_ff < best_key_ff)) begin
         found_in    = 1'b1;
         best_in     = cmp_idx_ff;
         best_key_in = rd_data_ff;
      end

      case (state_ff)
         STATE_IDLE: begin
            if (accept) begin
               rsp_slot_in  = '0;
               rsp_count_in = '0;
               rsp_stamp_in = '0;
               case (req_command)
                  CMD_ADD: begin
                     rsp_valid_in = 1'b1;
                     if (slot_ok) begin
                        wr_en                = 1'b1;
                        tracked_in[req_addr] = 1'b1;
                        rsp_status_in        = STATUS_OK;
                     end else begin
                        rsp_status_in = STATUS_UNTRACKED;
                     end
                  end
                  CMD_REMOVE: begin
                     rsp_valid_in = 1'b1;
                     if (slot_ok && tracked_ff[req_addr]) begin
                        tracked_in[req_addr] = 1'b0;
                        rsp_status_in        = STATUS_OK;
                     end else begin
                        rsp_status_in = STATUS_UNTRACKED;
                     end
                  end
                  CMD_EVICT: begin
                     state_in    = STATE_SCAN;
                     scan_idx_in = '0;
                     found_in    = 1'b0;
                  end
                  default: begin
                     rsp_valid_in  = 1'b1;
                     rsp_status_in = STATUS_OK;
                  end
               endcase
            end
         end
         STATE_SCAN: begin
            cmp_valid_in = scan_live && tracked_ff[rd_addr];
            cmp_idx_in   = rd_addr;
            if (scan_live) begin
               scan_idx_in = scan_idx_ff + 1'b1;
            end else begin
               state_in = STATE_DONE;
            end
         end
         STATE_DONE: begin
            state_in     = STATE_IDLE;
            rsp_valid_in = 1'b1;
            if (found_ff) begin
               tracked_in[best_ff] = 1'b0;
               rsp_status_in       = STATUS_OK;
               rsp_slot_in         = best_ext[SLOT_W-1:0];
               rsp_count_in        = best_key_ff[KEY_W-1:STAMP_W];
               rsp_stamp_in        = best_key_ff[STAMP_W-1:0];
            end else begin
               rsp_status_in = STATUS_EMPTY;
               rsp_slot_in   = '0;
               rsp_count_in  = '0;
               rsp_stamp_in  = '0;
            end
         end
         default: begin
            state_in = STATE_IDLE;
         end
      endcase
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_status       = rsp_status_ff;
   assign rsp_victim_slot  = rsp_slot_ff;
   assign rsp_victim_count = rsp_count_ff;
   assign rsp_victim_stamp = rsp_stamp_ff;

`ifndef SYNTHESIS
   a_evict_starts_scan: assert property (@(posedge clock) disable iff (reset)
      (accept && req_command == CMD_EVICT) |=> (state_ff == STATE_SCAN && !rsp_valid_ff))
      else $error("evict did not start a scan");

   a_done_slot_free: assert property (@(posedge clock) disable iff (reset)
      state_ff == STATE_DONE |-> !rsp_valid_ff)
      else $error("result register busy at end of scan");

   a_victim_tracked: assert property (@(posedge clock) disable iff (reset)
      (state_ff == STATE_DONE && found_ff) |-> tracked_ff[best_ff])
      else $error("chosen victim is not tracked");

   a_scan_bound: assert property (@(posedge clock) disable iff (reset)
      state_ff == STATE_SCAN |-> scan_idx_ff <= SLOTS_N)
      else $error("scan index past slot count");

   a_fail_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_status != STATUS_OK) |->
         (rsp_victim_slot == '0 && rsp_victim_count == '0 && rsp_victim_stamp == '0))
      else $error("failed beat carries victim data");
`endif

endmodule
